>>> hw/rtl/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
   localparam logic [1:0] KIND_EMPTY    = 2'd2;
   localparam logic [1:0] KIND_MASK_ERR = 2'd3;

   // one result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [63:0] byte_offset;
      logic        last_byte;
      logic        final_fragment;
      logic [3:0]  frame_opcode;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/wsd_parser.sv
`default_nettype none

module wsd_parser (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      stream_byte,
   output wsd_pkg::rsp_type     result
);

   // parser phases
   localparam logic [3:0] PH_HEAD  = 4'd0;
   localparam logic [3:0] PH_LEN   = 4'd1;
   localparam logic [3:0] PH_EXT64 = 4'd2;
   localparam logic [3:0] PH_EXT16 = 4'd8;
   localparam logic [3:0] PH_KEY0  = 4'd10;
   localparam logic [3:0] PH_KEY3  = 4'd13;
   localparam logic [3:0] PH_DATA  = 4'd14;

   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam logic [6:0] LEN_EXT16 = 7'd126;

   logic [3:0]  phase_ff,  phase_in;
   logic        fin_ff,    fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] offset_ff, offset_in;
   logic [7:0]  key_ff [4];
   logic        key_we;
   logic [1:0]  key_idx;

   // key slot follows the low phase bits: key0 at phase ten
   assign key_idx = phase_ff[1:0] - 2'd2;
   assign key_we  = (phase_ff >= PH_KEY0) && (phase_ff <= PH_KEY3);

   // next state and result for the incoming byte
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      length_in = length_ff;
      offset_in = offset_ff;
      result.kind         = wsd_pkg::KIND_HEADER;
      result.payload_byte = 8'd0;
      result.byte_offset  = 64'd0;
      result.last_byte    = 1'b0;
      case (phase_ff)
         PH_HEAD: begin
            fin_in    = stream_byte[7];
            opcode_in = stream_byte[3:0];
            phase_in  = PH_LEN;
         end
         PH_LEN: begin
            if (!stream_byte[7]) begin
               result.kind = wsd_pkg::KIND_MASK_ERR;
            end else if (stream_byte[6:0] == LEN_EXT64) begin
               length_in = 64'd0;
               phase_in  = PH_EXT64;
            end else if (stream_byte[6:0] == LEN_EXT16) begin
               length_in = 64'd0;
               phase_in  = PH_EXT16;
            end else begin
               length_in = {57'd0, stream_byte[6:0]};
               phase_in  = PH_KEY0;
            end
         end
         PH_KEY3: begin
            offset_in = 64'd0;
            if (length_ff == 64'd0) begin
               result.kind = wsd_pkg::KIND_EMPTY;
               phase_in    = PH_HEAD;
            end else begin
               phase_in = PH_DATA;
            end
         end
         default: begin
            if (key_we) begin
               phase_in = phase_ff + 4'd1;
            end else if (phase_ff >= PH_EXT64 && phase_ff < PH_KEY0) begin
               // extended length, big-endian
               length_in = {length_ff[55:0], stream_byte};
               phase_in  = phase_ff + 4'd1;
            end else begin
               // payload byte, also the unreachable phase fifteen
               result.kind         = wsd_pkg::KIND_PAYLOAD;
               result.byte_offset  = offset_ff;
               result.payload_byte = stream_byte ^ key_ff[offset_ff[1:0]];
               offset_in           = offset_ff + 64'd1;
               if (offset_in >= length_ff) begin
                  result.last_byte = 1'b1;
                  phase_in         = PH_HEAD;
               end
            end
         end
      endcase
      result.final_fragment = fin_in;
      result.frame_opcode   = opcode_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         length_ff <= 64'd0;
         offset_ff <= 64'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         length_ff <= length_in;
         offset_ff <= offset_in;
      end
   end

   // masking key, written before any payload read
   always_ff @(posedge clock) begin
      if (accept && key_we) begin
         key_ff[key_idx] <= stream_byte;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/wsd_rsp_buf.sv
`default_nettype none

module wsd_rsp_buf (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire wsd_pkg::rsp_type in_data,
   input  wire logic            rsp_stall,
   output logic                 rsp_valid,
   output wsd_pkg::rsp_type     rsp_data,
   output logic                 full
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   wsd_pkg::rsp_type main_ff;
   wsd_pkg::rsp_type skid_ff;
   logic             out_take;

   assign out_take  = main_valid_ff && !rsp_stall;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;
   assign full      = skid_valid_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (in_valid) begin
         main_valid_ff <= 1'b1;
         if (main_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         main_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            main_ff <= skid_ff;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || out_take) begin
            main_ff <= in_data;
         end else begin
            skid_ff <= in_data;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/websocket_frame_deframer.sv
// each result is registered into the output buffer when its byte is accepted
// throughput: one byte per cycle while the output buffer is not full
// a two-entry output buffer (main, skid) takes one more byte during output stall
// reset: synchronous, active high; clears parser phase, flags, length, offset
// and output valid flags; the masking key is not cleared
`default_nettype none

module websocket_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [63:0]      rsp_byte_offset,
   output logic             rsp_last_byte,
   output logic             rsp_final_fragment,
   output logic [3:0]       rsp_frame_opcode
);

   logic             accept;
   logic             buf_full;
   wsd_pkg::rsp_type result;
   wsd_pkg::rsp_type rsp_data;

   // input transfer
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .result      (result)
   );

   wsd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (buf_full)
   );

   // result fields
   assign rsp_kind           = rsp_data.kind;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_byte_offset    = rsp_data.byte_offset;
   assign rsp_last_byte      = rsp_data.last_byte;
   assign rsp_final_fragment = rsp_data.final_fragment;
   assign rsp_frame_opcode   = rsp_data.frame_opcode;

   // checks
   a_payload_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != wsd_pkg::KIND_PAYLOAD) |->
      (rsp_payload_byte == 8'd0 && rsp_byte_offset == 64'd0 && !rsp_last_byte))
      else $error("non-payload result carries payload fields");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output buffer not empty after reset");

   a_stall_drains: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !rsp_stall) |=> !req_stall)
      else $error("skid entry not drained after output transfer");

endmodule

`default_nettype wire
